// ===== sv/mqss_pkg.sv =====
//------------------------------------------------------------------------------
// mqss_pkg
// Shared widths, command and status codes for the shortest-select queue block.
//------------------------------------------------------------------------------
`default_nettype none
package mqss_pkg;
   localparam int NUM_QUEUES_DEF  = 8;
   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int ID_WIDTH_DEF    = 16;

   localparam int CMD_W    = 3;
   localparam int QSEL_W   = 3;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 5;
   localparam int LEN_W    = 6;

   localparam logic [CMD_W-1:0] CMD_PUSH     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POSITION = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SET_OPEN = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SHORTEST = 3'd5;
   // spare codes: no operation, report the addressed queue's length
   localparam logic [CMD_W-1:0] CMD_SPARE_6  = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7  = 3'd7;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NONE_OPEN = 3'd4;
endpackage
`default_nettype wire

// ===== sv/mqss_if.sv =====
//------------------------------------------------------------------------------
// mqss_req_if / mqss_rsp_if
// Valid/ready channels for command and result transactions.
//------------------------------------------------------------------------------
`default_nettype none
interface mqss_req_if #(parameter int ID_WIDTH = 16);
   logic                valid;
   logic                ready;
   logic [2:0]          cmd;
   logic [2:0]          queue_sel;
   logic [ID_WIDTH-1:0] item_id;
   logic                open_value;
   modport source (output valid, cmd, queue_sel, item_id, open_value, input ready);
   modport sink   (input valid, cmd, queue_sel, item_id, open_value, output ready);
endinterface

interface mqss_rsp_if #(parameter int ID_WIDTH = 16);
   logic                valid;
   logic                ready;
   logic [2:0]          status;
   logic [ID_WIDTH-1:0] popped_id;
   logic [4:0]          position;
   logic [5:0]          queue_len;
   logic [2:0]          chosen_queue;
   modport source (output valid, status, popped_id, position, queue_len, chosen_queue,
                   input ready);
   modport sink   (input valid, status, popped_id, position, queue_len, chosen_queue,
                   output ready);
endinterface
`default_nettype wire

// ===== sv/multi_queue_with_shortest_select.sv =====
//------------------------------------------------------------------------------
// multi_queue_with_shortest_select
// Bounded FIFO queues of ids in one shared memory, with search/remove and
// selection of the shortest open queue.
//------------------------------------------------------------------------------
// channel  | dir | payload
// req_     | in  | cmd, queue_sel, item_id, open_value
// rsp_     | out | status, popped_id, position, queue_len, chosen_queue
//
// One transaction at a time. After the accept the command passes the read state,
// then for pop, position and remove a walk over the queue's places (remove then
// shifts the tail forward one entry a clock), for shortest a scan over all
// NUM_QUEUES queues, then the done state, which loads the output register. Push,
// set open, spare codes and empty/full cases go straight from read to done. A walk
// reads the memory one place a clock. Reset is synchronous; the memory needs no
// clearing. A stalled result holds in the output register and the next command waits until it is taken.
//------------------------------------------------------------------------------
`default_nettype none
module multi_queue_with_shortest_select
   import mqss_pkg::*;
#(
   parameter int NUM_QUEUES  = mqss_pkg::NUM_QUEUES_DEF,
   parameter int QUEUE_DEPTH = mqss_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_WIDTH    = mqss_pkg::ID_WIDTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   mqss_req_if.sink   req,
   mqss_rsp_if.source rsp
);
   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = QW + PW;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_WALK  = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   // addressed as {queue, slot}
   logic [ID_WIDTH-1:0] mem [2**AW];
   logic [ID_WIDTH-1:0] rd_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_wa, mem_ra;
   logic [ID_WIDTH-1:0] mem_wd;

   logic [PW-1:0] head_ff [NUM_QUEUES];
   logic [CW-1:0] cnt_ff  [NUM_QUEUES];
   logic [NUM_QUEUES-1:0] open_ff;

   logic [2:0] state_ff, state_in;
   logic [2:0] cmd_ff;
   logic [QW-1:0] q_ff;
   logic [ID_WIDTH-1:0] id_ff;
   logic ov_ff, qok_ff;
   logic [CW-1:0] k_ff, k_in;     // logical place walked
   logic [QW-1:0] si_ff;          // scan index
   logic [CW-1:0] best_len_ff;
   logic [QW-1:0] best_ff;
   logic found_ff;

   logic [CW-1:0] pos_ff;
   logic [2:0] st_ff;
   logic [ID_WIDTH-1:0] pop_ff;

   logic out_v_ff;
   logic [2:0] o_st_ff;
   logic [ID_WIDTH-1:0] o_pop_ff;
   logic [4:0] o_pos_ff;
   logic [5:0] o_len_ff;
   logic [2:0] o_ch_ff;

   wire acc = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE) && !out_v_ff;
   assign rsp.valid = out_v_ff;
   assign rsp.status = o_st_ff;
   assign rsp.popped_id = o_pop_ff;
   assign rsp.position = o_pos_ff;
   assign rsp.queue_len = o_len_ff;
   assign rsp.chosen_queue = o_ch_ff;

   // slot of logical place k in current queue
   function automatic logic [AW-1:0] slot(input logic [QW-1:0] q, input logic [PW-1:0] h,
                                          input logic [CW-1:0] k);
      logic [CW:0] s;
      s = (CW+1)'(h) + (CW+1)'(k);
      if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
      return {q, s[PW-1:0]};
   endfunction

   // memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[mem_ra];
   end

   wire [CW-1:0] cnt_q = cnt_ff[q_ff];
   wire [PW-1:0] hd_q  = head_ff[q_ff];
   // rd_ff holds place k_ff while walking
   wire hit = (rd_ff == id_ff);

   // control
   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      mem_we = 1'b0;
      mem_wa = slot(q_ff, hd_q, cnt_q);
      mem_wd = id_ff;
      mem_ra = slot(q_ff, hd_q, k_ff + 1'b1);
      unique case (state_ff)
         S_IDLE: if (acc) state_in = S_READ;
         S_READ: begin
            k_in = '0;
            mem_ra = slot(q_ff, hd_q, '0);
            if (cmd_ff == CMD_SHORTEST) state_in = S_SCAN;
            else if (!qok_ff) state_in = S_DONE;
            else if ((cmd_ff == CMD_POP || cmd_ff == CMD_REMOVE ||
                      cmd_ff == CMD_POSITION) && cnt_q != '0)
               state_in = S_WALK;
            else begin
               state_in = S_DONE;
               if (cmd_ff == CMD_PUSH && cnt_q < CW'(QUEUE_DEPTH)) mem_we = 1'b1;
            end
         end
         S_WALK: begin
            if (cmd_ff == CMD_POP || hit) begin
               if (cmd_ff == CMD_REMOVE && k_ff + 1'b1 < cnt_q) state_in = S_SHIFT;
               else state_in = S_DONE;
            end else if (k_ff + 1'b1 == cnt_q) begin
               state_in = S_DONE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_SHIFT: begin
            // rd_ff holds place k+1; move it into k and fetch k+2
            mem_we = 1'b1;
            mem_wa = slot(q_ff, hd_q, k_ff);
            mem_wd = rd_ff;
            mem_ra = slot(q_ff, hd_q, k_ff + 2'd2);
            k_in = k_ff + 1'b1;
            if (k_ff + 2'd2 >= cnt_q) state_in = S_DONE;
         end
         S_SCAN: if (32'(si_ff) == NUM_QUEUES - 1) state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
         open_ff <= '0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         // result register: set when done, cleared when taken
         if (state_ff == S_DONE) out_v_ff <= 1'b1;
         else if (rsp.valid && rsp.ready) out_v_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (acc) begin
               cmd_ff <= req.cmd;
               q_ff <= QW'(req.queue_sel);
               qok_ff <= 32'(req.queue_sel) < NUM_QUEUES;
               id_ff <= req.item_id;
               ov_ff <= req.open_value;
               st_ff <= ST_OK;
               pos_ff <= '0;
               pop_ff <= '0;
               si_ff <= '0;
               found_ff <= 1'b0;
               best_ff <= '0;
               best_len_ff <= '0;
            end
            S_READ: if (cmd_ff != CMD_SHORTEST && qok_ff) begin
               unique case (cmd_ff) inside
                  CMD_PUSH:
                     if (cnt_q >= CW'(QUEUE_DEPTH)) st_ff <= ST_FULL;
                     else cnt_ff[q_ff] <= cnt_q + 1'b1;
                  CMD_POP:
                     if (cnt_q == '0) st_ff <= ST_EMPTY;
                  CMD_REMOVE, CMD_POSITION:
                     if (cnt_q == '0) st_ff <= ST_NOT_FOUND;
                  CMD_SET_OPEN: open_ff[q_ff] <= ov_ff;
                  default: ;
               endcase
            end
            S_WALK: begin
               if (cmd_ff == CMD_POP) begin
                  pop_ff <= rd_ff;
                  head_ff[q_ff] <= (32'(hd_q) + 1 >= QUEUE_DEPTH) ? '0 : hd_q + 1'b1;
                  cnt_ff[q_ff] <= cnt_q - 1'b1;
               end else if (hit) begin
                  pos_ff <= k_ff;
                  // hit on the tail: nothing to shift
                  if (cmd_ff == CMD_REMOVE && k_ff + 1'b1 >= cnt_q)
                     cnt_ff[q_ff] <= cnt_q - 1'b1;
               end else if (k_ff + 1'b1 == cnt_q) begin
                  st_ff <= ST_NOT_FOUND;
               end
            end
            S_SHIFT: if (state_in == S_DONE) cnt_ff[q_ff] <= cnt_q - 1'b1;
            S_SCAN: begin
               if (open_ff[si_ff] && (!found_ff || cnt_ff[si_ff] < best_len_ff)) begin
                  found_ff <= 1'b1;
                  best_ff <= si_ff;
                  best_len_ff <= cnt_ff[si_ff];
               end
               si_ff <= si_ff + 1'b1;
            end
            S_DONE: begin
               o_pop_ff <= pop_ff;
               o_pos_ff <= 5'(pos_ff);
               if (cmd_ff == CMD_SHORTEST) begin
                  o_st_ff <= found_ff ? ST_OK : ST_NONE_OPEN;
                  o_ch_ff <= found_ff ? 3'(best_ff) : 3'd0;
                  o_len_ff <= found_ff ? 6'(best_len_ff) : 6'd0;
               end else begin
                  o_st_ff <= st_ff;
                  o_ch_ff <= 3'd0;
                  o_len_ff <= qok_ff ? 6'(cnt_q) : 6'd0;
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== sv/mqss_checker.sv =====
//------------------------------------------------------------------------------
// mqss_checker
// Port-level checks on the command and result channels.
//------------------------------------------------------------------------------
`default_nettype none
module mqss_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_status,
   input wire logic [2:0] rsp_chosen_queue
);
   import mqss_pkg::*;

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped while stalled");
   // no new command accepted while a result waits
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("command accepted with result pending");
   // a command never yields a result in the very next cycle
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("result too early");
   // none open carries queue zero
   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NONE_OPEN |-> rsp_chosen_queue == 3'd0)
      else $error("chosen queue set with none open");
endmodule

bind multi_queue_with_shortest_select mqss_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_chosen_queue(rsp.chosen_queue));
`default_nettype wire
